FILE: src/vvsr_pkg.sv
// vvsr_pkg: shared types, constants and step functions for the slip ratio pipeline
// no dependencies
package vvsr_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned MaxWheels = 4;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 15;
  // input regs, sums, sqrt steps, slip setup, divide steps, output reg
  localparam int unsigned NumStages = 1 + 1 + SqrtSteps + 1 + DivSteps + 1;
  localparam int unsigned StSqrt0   = 2;
  localparam int unsigned StDivIn   = StSqrt0 + SqrtSteps;
  localparam int unsigned StDiv0    = StDivIn + 1;
  localparam int unsigned StOut     = NumStages - 1;
  localparam logic [15:0] ThrReset  = 16'd128;

  typedef struct packed {
    logic [2:0][15:0] loc;
    logic [MaxWheels-1:0][15:0] wheel;
    logic             active;
    logic [31:0]      x;
    logic [19:0]      rem;
    logic [15:0]      root;
  } sq_t;

  typedef struct packed {
    logic [14:0] n;
    logic [16:0] rem;
    logic [14:0] q;
    logic        neg;
    logic        sat;
  } lane_t;

  typedef struct packed {
    logic [2:0][15:0] loc;
    logic             active;
    logic [16:0]      s;
    lane_t [MaxWheels-1:0] lane;
  } dv_t;

  function automatic sq_t sqrt_step(sq_t a);
    sq_t        r;
    logic [19:0] rem_n;
    logic [19:0] trial;
    r     = a;
    rem_n = {a.rem[17:0], a.x[31:30]};
    trial = {2'b00, a.root, 2'b01};
    r.x   = {a.x[29:0], 2'b00};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {a.root[14:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {a.root[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lane_t div_step(lane_t a, logic [16:0] s);
    lane_t       r;
    logic [17:0] rem_n;
    r     = a;
    rem_n = {a.rem, a.n[14]};
    r.n   = {a.n[13:0], 1'b0};
    if (rem_n >= {1'b0, s}) begin
      r.rem = 17'(rem_n - {1'b0, s});
      r.q   = {a.q[13:0], 1'b1};
    end else begin
      r.rem = rem_n[16:0];
      r.q   = {a.q[13:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] dot_round(logic signed [31:0] a, logic signed [31:0] b,
                                            logic signed [31:0] c);
    logic signed [34:0] sum;
    logic signed [20:0] sh;
    sum = 35'(a) + 35'(b) + 35'(c) + 35'sd8192;
    sh  = 21'(sum >>> 14);
    if (sh > 21'sd32767) begin
      return 16'h7fff;
    end else if (sh < -21'sd32768) begin
      return 16'h8000;
    end else begin
      return sh[15:0];
    end
  endfunction

endpackage

FILE: src/vehicle_velocity_slip_ratio.sv
// vehicle_velocity_slip_ratio: local velocity projection and per-wheel slip ratio
// depends on vvsr_pkg
//
// usage
//   input channel: valid_i / stall_o with one telemetry frame per transfer
//   output channel: valid_o / stall_i with local velocity and four slip ratios
//   config: cfg_we_i writes cfg_data_i into the speed threshold (reset 0.5 m/s)
// timing
//   valid_o rises when a frame has passed two stages of products and sums,
//   sixteen square root stages (one root bit each), one slip setup stage,
//   fifteen restoring divide stages (one quotient bit each for all four
//   wheels) and reached the output register, 35 registers in all
//   throughput is one frame per cycle unless every stage is full and
//   stall_i is high
// reset and flow control
//   reset empties the pipeline and loads the threshold reset value
//   each stage holds its frame while the next one is full and held; empty
//   stages keep filling, so frames are still taken while the output waits,
//   until every stage is full and stall_i is high
module vehicle_velocity_slip_ratio (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [15:0] world_vel_x_i,
  input  logic [15:0] world_vel_y_i,
  input  logic [15:0] world_vel_z_i,
  input  logic [47:0] axis_right_i,
  input  logic [47:0] axis_up_i,
  input  logic [47:0] axis_forward_i,
  input  logic [15:0] wheel_speed_0_i,
  input  logic [15:0] wheel_speed_1_i,
  input  logic [15:0] wheel_speed_2_i,
  input  logic [15:0] wheel_speed_3_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [15:0] local_right_o,
  output logic [15:0] local_forward_o,
  output logic [15:0] local_up_o,
  output logic [15:0] slip_0_o,
  output logic [15:0] slip_1_o,
  output logic [15:0] slip_2_o,
  output logic [15:0] slip_3_o
);
  import vvsr_pkg::*;

  logic [15:0] thr_q;
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // stage advances when empty or when the next one advances
  always_comb begin
    en[StOut] = !vld_q[StOut] || !stall_i;
    for (int k = StOut - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[StOut];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 0: products
  logic signed [2:0][2:0][31:0] prod_q;
  logic [2:0][30:0] sq_q;
  logic [31:0] thr_sq_q;
  logic [MaxWheels-1:0][15:0] wh0_q;
  logic [2:0][15:0] vel;
  logic [2:0][47:0] axes;

  assign vel  = {world_vel_z_i, world_vel_y_i, world_vel_x_i};
  assign axes = {axis_up_i, axis_forward_i, axis_right_i};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[a][c] <= $signed(vel[c]) * $signed(axes[a][16*c +: 16]);
        end
        sq_q[a] <= 31'($signed(vel[a]) * $signed(vel[a]));
      end
      thr_sq_q <= thr_q * thr_q;
      wh0_q    <= {wheel_speed_3_i, wheel_speed_2_i, wheel_speed_1_i, wheel_speed_0_i};
    end
  end

  // stage 1: dot rounding, sum of squares, threshold test
  sq_t s1_q;
  logic [31:0] sumsq;
  assign sumsq = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        s1_q.loc[a] <= dot_round(prod_q[a][0], prod_q[a][1], prod_q[a][2]);
      end
      s1_q.wheel  <= wh0_q;
      s1_q.active <= (sumsq >= thr_sq_q) && (sumsq != 32'd0);
      s1_q.x      <= sumsq;
      s1_q.rem    <= '0;
      s1_q.root   <= '0;
    end
  end

  // square root stages
  sq_t sq_st_q [SqrtSteps];
  always_ff @(posedge clk_i) begin
    if (en[StSqrt0]) begin
      sq_st_q[0] <= sqrt_step(s1_q);
    end
    for (int k = 1; k < SqrtSteps; k++) begin
      if (en[StSqrt0 + k]) begin
        sq_st_q[k] <= sqrt_step(sq_st_q[k-1]);
      end
    end
  end

  // slip setup
  dv_t dv_in;
  always_comb begin
    logic [16:0] s;
    logic signed [17:0] diff;
    logic [16:0] mag;
    logic [29:0] num;
    s            = {1'b0, sq_st_q[SqrtSteps-1].root};
    dv_in.loc    = sq_st_q[SqrtSteps-1].loc;
    dv_in.active = sq_st_q[SqrtSteps-1].active;
    dv_in.s      = s;
    for (int w = 0; w < MaxWheels; w++) begin
      diff = $signed({1'b0, s}) - 18'($signed(sq_st_q[SqrtSteps-1].wheel[w]));
      mag  = diff[17] ? 17'(-diff) : diff[16:0];
      num  = {1'b0, mag, 12'd0} + 30'(s[16:1]);
      dv_in.lane[w].neg = diff[17];
      dv_in.lane[w].sat = {2'b00, num} >= {s, 15'd0};
      dv_in.lane[w].rem = {2'b00, num[29:15]};
      dv_in.lane[w].n   = num[14:0];
      dv_in.lane[w].q   = '0;
    end
  end

  dv_t dv_st_q [DivSteps + 1];
  always_ff @(posedge clk_i) begin
    if (en[StDivIn]) begin
      dv_st_q[0] <= dv_in;
    end
    for (int k = 1; k <= DivSteps; k++) begin
      if (en[StDiv0 + k - 1]) begin
        dv_st_q[k].loc    <= dv_st_q[k-1].loc;
        dv_st_q[k].active <= dv_st_q[k-1].active;
        dv_st_q[k].s      <= dv_st_q[k-1].s;
        for (int w = 0; w < MaxWheels; w++) begin
          dv_st_q[k].lane[w] <= div_step(dv_st_q[k-1].lane[w], dv_st_q[k-1].s);
        end
      end
    end
  end

  // output register
  logic [2:0][15:0] loc_q;
  logic [MaxWheels-1:0][15:0] slip_q;
  always_ff @(posedge clk_i) begin
    if (en[StOut]) begin
      loc_q <= dv_st_q[DivSteps].loc;
      for (int w = 0; w < MaxWheels; w++) begin
        if (!dv_st_q[DivSteps].active || w >= NumWheels) begin
          slip_q[w] <= '0;
        end else if (dv_st_q[DivSteps].lane[w].sat) begin
          slip_q[w] <= dv_st_q[DivSteps].lane[w].neg ? 16'h8000 : 16'h7fff;
        end else if (dv_st_q[DivSteps].lane[w].neg) begin
          slip_q[w] <= 16'(-{1'b0, dv_st_q[DivSteps].lane[w].q});
        end else begin
          slip_q[w] <= {1'b0, dv_st_q[DivSteps].lane[w].q};
        end
      end
    end
  end

  assign local_right_o   = loc_q[0];
  assign local_forward_o = loc_q[1];
  assign local_up_o      = loc_q[2];
  assign slip_0_o        = slip_q[0];
  assign slip_1_o        = slip_q[1];
  assign slip_2_o        = slip_q[2];
  assign slip_3_o        = slip_q[3];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&vld_q) && stall_i)
    else $error("input stalled with a bubble in the pipeline");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(slip_0_o) && $stable(local_up_o))
    else $error("stalled output transfer changed");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDivIn] && !en[StDivIn] |=> vld_q[StDivIn])
    else $error("held frame lost in the divide stages");

endmodule
